// ----- rtl/slpg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the status LED pattern generator.
// No dependencies; every other file of the block but slpg_if refers to this package.
package slpg_pkg;

	// Item operation codes; code 3 is unused and leaves the state alone.
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_MODE     = 2'd1,
		OP_ACTIVITY = 2'd2
	} op_t;

	// Base modes of the LED.
	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_AP    = 2'd1,
		MODE_CONN  = 2'd2,
		MODE_READY = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_AP_ON         = 3'd0;
	localparam cfg_idx_t CFG_AP_OFF        = 3'd1;
	localparam cfg_idx_t CFG_CONN_ON       = 3'd2;
	localparam cfg_idx_t CFG_CONN_OFF      = 3'd3;
	localparam cfg_idx_t CFG_CONN_GAP      = 3'd4;
	localparam cfg_idx_t CFG_ACT_DARK      = 3'd5;
	localparam cfg_idx_t CFG_ACT_GAP       = 3'd6;
	localparam cfg_idx_t CFG_ACTIVE_LEVEL  = 3'd7;

	// Reset values of the duration and level registers.
	localparam int unsigned RST_AP_ON        = 500;
	localparam int unsigned RST_AP_OFF       = 500;
	localparam int unsigned RST_CONN_ON      = 100;
	localparam int unsigned RST_CONN_OFF     = 100;
	localparam int unsigned RST_CONN_GAP     = 700;
	localparam int unsigned RST_ACT_DARK     = 50;
	localparam int unsigned RST_ACT_GAP      = 50;
	localparam logic        RST_ACTIVE_LEVEL = 1'b1;

endpackage

// ----- rtl/slpg_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the item and result streams.
// Depends on nothing; used by the top level ports.
interface slpg_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] new_mode;

	modport source (output valid, output op, output new_mode, input ready);
	modport sink   (input valid, input op, input new_mode, output ready);
endinterface

interface slpg_result_if;
	logic valid;
	logic ready;
	logic led_level;

	modport source (output valid, output led_level, input ready);
	modport sink   (input valid, input led_level, output ready);
endinterface

// ----- rtl/status_led_pattern_generator_core.sv -----
`timescale 1ns / 1ps
// Status LED pattern generator, top level.
// Depends on slpg_pkg, slpg_if (slpg_item_if, slpg_result_if) and slpg_pattern.
//
// Takes one beat per clock: a millisecond tick, a base mode change or an
// activity notice, and returns one beat with the LED pin level after that
// item. Every item is handled combinationally: the next mode, phase and
// activity counters and the resulting level are worked out from the state
// registers and written together, the level into an output register at the
// edge that takes the beat. A new item is taken in every cycle, also while
// the previous result still waits, as long as that result leaves this cycle
// (ready = output register empty or being drained). Modes: initializing
// (dark), access point (blink, period ap_on + ap_off), connecting (two
// flashes then a gap, period 2*conn_on + conn_off + conn_gap) and ready
// (always lit). The phase counter wraps at the period of the current mode;
// after a register write that shrinks the period it wraps on the next tick.
// An activity notice darkens the LED for activity_dark ticks and blocks new
// notices for a further activity_gap ticks. Configuration writes are taken
// at any edge with cfg_we high and should come only while the block is idle.
module status_led_pattern_generator_core #(
	parameter int DURATION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  slpg_pkg::cfg_idx_t        cfg_index,
	input  logic [DURATION_BITS-1:0]  cfg_data,
	slpg_item_if.sink                 item_in,
	slpg_result_if.source             result_out
);
	localparam int D  = DURATION_BITS;
	localparam int HW = DURATION_BITS + 1;  // holdoff: dark + gap
	localparam int PW = DURATION_BITS + 2;  // phase: up to four durations

	// configuration registers
	logic [D-1:0] ap_on_q, ap_off_q, conn_on_q, conn_off_q, conn_gap_q;
	logic [D-1:0] act_dark_q, act_gap_q;
	logic         act_level_q;

	// pattern state
	slpg_pkg::mode_t mode_q, mode_nxt;
	logic [PW-1:0]   phase_q, phase_nxt;
	logic [D-1:0]    dark_q, dark_nxt;
	logic [HW-1:0]   hold_q, hold_nxt;

	// output register
	logic out_valid_q;
	logic led_q;

	logic          accept;
	logic [PW-1:0] period;
	logic [PW-1:0] phase_inc;
	logic          pattern_on;
	logic          level_nxt;

	assign item_in.ready     = !out_valid_q || result_out.ready;
	assign accept            = item_in.valid && item_in.ready;
	assign result_out.valid  = out_valid_q;
	assign result_out.led_level = led_q;

	// period of the current mode; init and ready hold the phase at zero
	always_comb begin
		case (mode_q)
			slpg_pkg::MODE_AP: begin
				period = PW'(ap_on_q) + PW'(ap_off_q);
			end
			slpg_pkg::MODE_CONN: begin
				period = PW'({conn_on_q, 1'b0}) + PW'(conn_off_q) + PW'(conn_gap_q);
			end
			default: begin
				period = '0;
			end
		endcase
	end

	assign phase_inc = phase_q + PW'(1);

	// next state for the item at the input
	always_comb begin
		mode_nxt  = mode_q;
		phase_nxt = phase_q;
		dark_nxt  = dark_q;
		hold_nxt  = hold_q;
		case (item_in.op)
			slpg_pkg::OP_TICK: begin
				phase_nxt = ((period == '0) || (phase_inc >= period)) ? '0 : phase_inc;
				if (dark_q != '0) begin
					dark_nxt = dark_q - D'(1);
				end
				if (hold_q != '0) begin
					hold_nxt = hold_q - HW'(1);
				end
			end
			slpg_pkg::OP_MODE: begin
				if (slpg_pkg::mode_t'(item_in.new_mode) != mode_q) begin
					mode_nxt  = slpg_pkg::mode_t'(item_in.new_mode);
					phase_nxt = '0;
				end
			end
			slpg_pkg::OP_ACTIVITY: begin
				// notices during dark time or holdoff are dropped
				if ((dark_q == '0) && (hold_q == '0)) begin
					dark_nxt = act_dark_q;
					hold_nxt = HW'(act_dark_q) + HW'(act_gap_q);
				end
			end
			default: begin
			end
		endcase
	end

	slpg_pattern #(
		.DURATION_BITS (DURATION_BITS)
	) u_pattern (
		.mode       (mode_nxt),
		.phase      (phase_nxt),
		.ap_on      (ap_on_q),
		.conn_on    (conn_on_q),
		.conn_off   (conn_off_q),
		.pattern_on (pattern_on)
	);

	assign level_nxt = ((dark_nxt == '0) && pattern_on) ? act_level_q : !act_level_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_on_q     <= D'(slpg_pkg::RST_AP_ON);
			ap_off_q    <= D'(slpg_pkg::RST_AP_OFF);
			conn_on_q   <= D'(slpg_pkg::RST_CONN_ON);
			conn_off_q  <= D'(slpg_pkg::RST_CONN_OFF);
			conn_gap_q  <= D'(slpg_pkg::RST_CONN_GAP);
			act_dark_q  <= D'(slpg_pkg::RST_ACT_DARK);
			act_gap_q   <= D'(slpg_pkg::RST_ACT_GAP);
			act_level_q <= slpg_pkg::RST_ACTIVE_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				slpg_pkg::CFG_AP_ON:        ap_on_q     <= cfg_data;
				slpg_pkg::CFG_AP_OFF:       ap_off_q    <= cfg_data;
				slpg_pkg::CFG_CONN_ON:      conn_on_q   <= cfg_data;
				slpg_pkg::CFG_CONN_OFF:     conn_off_q  <= cfg_data;
				slpg_pkg::CFG_CONN_GAP:     conn_gap_q  <= cfg_data;
				slpg_pkg::CFG_ACT_DARK:     act_dark_q  <= cfg_data;
				slpg_pkg::CFG_ACT_GAP:      act_gap_q   <= cfg_data;
				slpg_pkg::CFG_ACTIVE_LEVEL: act_level_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// pattern state, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= slpg_pkg::MODE_INIT;
			phase_q <= '0;
			dark_q  <= '0;
			hold_q  <= '0;
		end else if (accept) begin
			mode_q  <= mode_nxt;
			phase_q <= phase_nxt;
			dark_q  <= dark_nxt;
			hold_q  <= hold_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_q <= level_nxt;
		end
	end

	// holdoff always covers the remaining dark time
	a_hold_covers_dark: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q >= HW'(dark_q))
		else $error("holdoff shorter than dark time");

	// modes without a period keep the phase at zero
	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == slpg_pkg::MODE_INIT) || (mode_q == slpg_pkg::MODE_READY))
			|-> (phase_q == '0))
		else $error("phase moved in a mode without pattern");

	// every accepted beat leaves a result in the output register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted beat produced no result");

	// a forced-dark item yields the unlit level
	a_dark_level: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we && (dark_nxt != '0)) |=> (led_q != act_level_q))
		else $error("LED lit during activity dark time");
endmodule

// ----- rtl/slpg_pattern.sv -----
`timescale 1ns / 1ps
// Base pattern decode: is the LED on for a given mode and phase.
// Depends on slpg_pkg.
module slpg_pattern #(
	parameter int DURATION_BITS = 16
) (
	input  slpg_pkg::mode_t            mode,
	input  logic [DURATION_BITS+1:0]   phase,
	input  logic [DURATION_BITS-1:0]   ap_on,
	input  logic [DURATION_BITS-1:0]   conn_on,
	input  logic [DURATION_BITS-1:0]   conn_off,
	output logic                       pattern_on
);
	localparam int PW = DURATION_BITS + 2;

	logic [PW-1:0] second_on;
	logic [PW-1:0] second_off;

	assign second_on  = PW'(conn_on) + PW'(conn_off);
	assign second_off = second_on + PW'(conn_on);

	always_comb begin
		case (mode)
			slpg_pkg::MODE_AP: begin
				pattern_on = (phase < PW'(ap_on));
			end
			slpg_pkg::MODE_CONN: begin
				pattern_on = (phase < PW'(conn_on)) ||
					((phase >= second_on) && (phase < second_off));
			end
			slpg_pkg::MODE_READY: begin
				pattern_on = 1'b1;
			end
			default: begin
				pattern_on = 1'b0;
			end
		endcase
	end
endmodule

// ----- tb/sv/status_led_pattern_generator_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for status_led_pattern_generator_core.
// Depends on slpg_pkg, slpg_if and the block's RTL; a scoreboard class predicts
// each LED level from the accepted item beats and checks the result beats.
module status_led_pattern_generator_core_tb;

	localparam int DUR_BITS        = 16;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int N_PHASES        = 6;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int TAIL_CYCLES     = 4;
	localparam int MAX_REPORTS     = 10;
	localparam int unsigned DUR_MAX = (1 << DUR_BITS) - 1;

	// Op code 3 has no package name; the block must leave its state alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Idling schemes: sender/receiver stall percentages per phase pair.
	localparam int IDLE_SEND_A = 37;
	localparam int IDLE_RECV_A = 51;

	typedef enum {STYLE_SMALL, STYLE_ZERO, STYLE_MAX, STYLE_MIXED} setting_style_t;

	typedef struct {
		int unsigned ap_on;
		int unsigned ap_off;
		int unsigned conn_on;
		int unsigned conn_off;
		int unsigned conn_gap;
		int unsigned act_dark;
		int unsigned act_gap;
		logic        level;
	} led_setting_t;

	// Predicts the pin level after each item and checks the result beats
	// against the oldest pending prediction.
	class led_level_board;
		int unsigned       ap_on, ap_off, conn_on, conn_off, conn_gap;
		int unsigned       act_dark, act_gap;
		logic              lit_level;
		slpg_pkg::mode_t   mode;
		int unsigned       phase, dark_left, holdoff_left;
		logic              expected_levels[$];
		int unsigned       errors;
		int unsigned       results_seen;

		function new();
			ap_on        = slpg_pkg::RST_AP_ON;
			ap_off       = slpg_pkg::RST_AP_OFF;
			conn_on      = slpg_pkg::RST_CONN_ON;
			conn_off     = slpg_pkg::RST_CONN_OFF;
			conn_gap     = slpg_pkg::RST_CONN_GAP;
			act_dark     = slpg_pkg::RST_ACT_DARK;
			act_gap      = slpg_pkg::RST_ACT_GAP;
			lit_level    = slpg_pkg::RST_ACTIVE_LEVEL;
			mode         = slpg_pkg::MODE_INIT;
			phase        = 0;
			dark_left    = 0;
			holdoff_left = 0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void set_reg(slpg_pkg::cfg_idx_t idx, logic [DUR_BITS-1:0] val);
			case (idx)
				slpg_pkg::CFG_AP_ON:        ap_on     = 32'(val);
				slpg_pkg::CFG_AP_OFF:       ap_off    = 32'(val);
				slpg_pkg::CFG_CONN_ON:      conn_on   = 32'(val);
				slpg_pkg::CFG_CONN_OFF:     conn_off  = 32'(val);
				slpg_pkg::CFG_CONN_GAP:     conn_gap  = 32'(val);
				slpg_pkg::CFG_ACT_DARK:     act_dark  = 32'(val);
				slpg_pkg::CFG_ACT_GAP:      act_gap   = 32'(val);
				slpg_pkg::CFG_ACTIVE_LEVEL: lit_level = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned pattern_period();
			case (mode)
				slpg_pkg::MODE_AP:   return ap_on + ap_off;
				slpg_pkg::MODE_CONN: return 2 * conn_on + conn_off + conn_gap;
				default:             return 0;
			endcase
		endfunction

		function bit pattern_lit();
			case (mode)
				slpg_pkg::MODE_AP:    return phase < ap_on;
				slpg_pkg::MODE_CONN:  return (phase < conn_on) ||
					(phase >= conn_on + conn_off && phase < 2 * conn_on + conn_off);
				slpg_pkg::MODE_READY: return 1'b1;
				default:              return 1'b0;
			endcase
		endfunction

		function void note_item(logic [1:0] op, logic [1:0] nm);
			int unsigned period;
			case (op)
				slpg_pkg::OP_TICK: begin
					period = pattern_period();
					phase = (period == 0 || phase + 1 >= period) ? 0 : phase + 1;
					if (dark_left != 0) dark_left--;
					if (holdoff_left != 0) holdoff_left--;
				end
				slpg_pkg::OP_MODE: begin
					if (slpg_pkg::mode_t'(nm) != mode) begin
						mode  = slpg_pkg::mode_t'(nm);
						phase = 0;
					end
				end
				slpg_pkg::OP_ACTIVITY: begin
					// a notice inside the dark or hold-off window is dropped
					if (dark_left == 0 && holdoff_left == 0) begin
						dark_left    = act_dark;
						holdoff_left = act_dark + act_gap;
					end
				end
				default: ;
			endcase
			expected_levels.push_back((dark_left == 0 && pattern_lit()) ?
				lit_level : ~lit_level);
		endfunction

		function void check_level(logic got);
			logic want;
			results_seen++;
			if (expected_levels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("led_level beat %0b arrived with nothing pending", got);
			end else begin
				want = expected_levels.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("led_level mismatch on beat %0d: expected %0b, got %0b",
							results_seen, want, got);
				end
			end
		endfunction

		function int unsigned failures();
			return errors + expected_levels.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	slpg_pkg::cfg_idx_t    cfg_index;
	logic [DUR_BITS-1:0]   cfg_data;

	slpg_item_if   items_if ();
	slpg_result_if levels_if ();

	led_level_board levels_sb = new();

	int unsigned send_idle_pct = IDLE_SEND_A;
	int unsigned recv_idle_pct = IDLE_RECV_A;
	int unsigned beats_sent    = 0;
	int unsigned stall_cycles  = 0;

	setting_style_t phase_styles [N_PHASES] = '{STYLE_SMALL, STYLE_ZERO, STYLE_MAX,
		STYLE_SMALL, STYLE_MIXED, STYLE_SMALL};

	status_led_pattern_generator_core #(
		.DURATION_BITS(DUR_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_in   (items_if),
		.result_out(levels_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver side: random back-pressure on the level stream.
	always @(posedge clk) begin
		levels_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: check results before noting the item of the same edge, so a
	// result with nothing pending is never matched to a fresh prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (levels_if.valid && levels_if.ready)
				levels_sb.check_level(levels_if.led_level);
			if (items_if.valid && items_if.ready)
				levels_sb.note_item(items_if.op, items_if.new_mode);
		end
	end

	// Watchdog: too long without any beat or register write ends the run.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (items_if.valid && items_if.ready) ||
				(levels_if.valid && levels_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One item beat; random gaps with valid low come first.
	task automatic send_item(input logic [1:0] op, input logic [1:0] nm);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid    <= 1'b1;
		items_if.op       <= op;
		items_if.new_mode <= nm;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		beats_sent++;
	endtask

	// Hold the sender until every level beat has come back. The result count
	// is kept by the monitor and may lag behind, which only lengthens the wait.
	task automatic drain_levels();
		if (levels_sb.results_seen < beats_sent) begin
			items_if.valid <= 1'b0;
			while (levels_sb.results_seen < beats_sent) @(posedge clk);
		end
	endtask

	task automatic write_reg(input slpg_pkg::cfg_idx_t idx,
			input logic [DUR_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		levels_sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(input led_setting_t s);
		write_reg(slpg_pkg::CFG_AP_ON,        s.ap_on[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_AP_OFF,       s.ap_off[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_CONN_ON,      s.conn_on[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_CONN_OFF,     s.conn_off[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_CONN_GAP,     s.conn_gap[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_ACT_DARK,     s.act_dark[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_ACT_GAP,      s.act_gap[DUR_BITS-1:0]);
		write_reg(slpg_pkg::CFG_ACTIVE_LEVEL, {{(DUR_BITS-1){1'b0}}, s.level});
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_duration(setting_style_t style);
		case (style)
			STYLE_ZERO:  return 0;
			STYLE_MAX:   return DUR_MAX;
			STYLE_MIXED: return ($urandom_range(3) == 0) ? DUR_MAX : $urandom_range(1, 9);
			default:     return $urandom_range(0, 6);
		endcase
	endfunction

	function automatic led_setting_t make_setting(setting_style_t style);
		led_setting_t s;
		s.ap_on    = pick_duration(style);
		s.ap_off   = pick_duration(style);
		s.conn_on  = pick_duration(style);
		s.conn_off = pick_duration(style);
		s.conn_gap = pick_duration(style);
		s.act_dark = pick_duration(style);
		s.act_gap  = pick_duration(style);
		case (style)
			STYLE_ZERO:  s.level = 1'b0;
			STYLE_MAX:   s.level = 1'b1;
			default:     s.level = 1'($urandom_range(1));
		endcase
		return s;
	endfunction

	// Mostly ticks so the patterns actually run; mode changes lean toward the
	// blinking modes, plus activity notices and the unused op code.
	task automatic send_random_item();
		int unsigned pick;
		logic [1:0]  op;
		logic [1:0]  nm;
		pick = $urandom_range(99);
		nm   = 2'($urandom_range(3));
		if (pick < 68) begin
			op = slpg_pkg::OP_TICK;
		end else if (pick < 80) begin
			op = slpg_pkg::OP_MODE;
			if ($urandom_range(99) < 70)
				nm = $urandom_range(1) ? slpg_pkg::MODE_AP : slpg_pkg::MODE_CONN;
		end else if (pick < 93) begin
			op = slpg_pkg::OP_ACTIVITY;
		end else begin
			op = OP_UNUSED;
		end
		send_item(op, nm);
	endtask

	initial begin
		led_setting_t quick;

		items_if.valid    <= 1'b0;
		items_if.op       <= slpg_pkg::OP_TICK;
		items_if.new_mode <= slpg_pkg::MODE_INIT;
		cfg_we            <= 1'b0;
		cfg_index         <= slpg_pkg::CFG_AP_ON;
		cfg_data          <= '0;
		arst_n            <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset-value registers: unused op, new_mode ignored on a
		// tick, same mode twice, notice while already dark.
		send_item(OP_UNUSED,             slpg_pkg::MODE_READY);
		send_item(slpg_pkg::OP_TICK,     slpg_pkg::MODE_READY);
		send_item(slpg_pkg::OP_MODE,     slpg_pkg::MODE_READY);
		send_item(slpg_pkg::OP_MODE,     slpg_pkg::MODE_READY);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_CONN);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_AP);
		send_item(slpg_pkg::OP_MODE,     slpg_pkg::MODE_AP);
		send_item(slpg_pkg::OP_TICK,     slpg_pkg::MODE_INIT);

		// Short durations so dark window, hold-off and wrap show up quickly.
		quick = '{ap_on: 2, ap_off: 3, conn_on: 1, conn_off: 1, conn_gap: 2,
			act_dark: 2, act_gap: 3, level: 1'b0};
		drain_levels();
		apply_setting(quick);
		send_item(slpg_pkg::OP_MODE,     slpg_pkg::MODE_CONN);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_INIT);
		send_item(slpg_pkg::OP_TICK,     slpg_pkg::MODE_INIT);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_INIT);   // still dark: dropped
		send_item(slpg_pkg::OP_TICK,     slpg_pkg::MODE_INIT);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_INIT);   // in hold-off: dropped
		repeat (3) send_item(slpg_pkg::OP_TICK, slpg_pkg::MODE_INIT);
		send_item(slpg_pkg::OP_ACTIVITY, slpg_pkg::MODE_INIT);   // window over: taken
		send_item(slpg_pkg::OP_MODE,     slpg_pkg::MODE_AP);
		repeat (4) send_item(slpg_pkg::OP_TICK, slpg_pkg::MODE_AP);

		// Shrink the AP period under a phase of 4: compared as is, wraps next tick.
		quick.ap_on  = 1;
		quick.ap_off = 1;
		drain_levels();
		apply_setting(quick);
		send_item(slpg_pkg::OP_TICK, slpg_pkg::MODE_AP);
		send_item(slpg_pkg::OP_TICK, slpg_pkg::MODE_AP);

		// Random phases, each with its own register setting and idling scheme.
		for (int p = 0; p < N_PHASES; p++) begin
			drain_levels();
			apply_setting(make_setting(phase_styles[p]));
			case (p / 2)
				0: begin
					send_idle_pct = IDLE_SEND_A;
					recv_idle_pct = IDLE_RECV_A;
				end
				1: begin
					send_idle_pct = IDLE_RECV_A;
					recv_idle_pct = IDLE_SEND_A;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					drain_levels();
				send_random_item();
			end
		end

		drain_levels();
		items_if.valid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		if (levels_sb.failures() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
